### design/rcs_pkg.sv
// Package for the range coder step unit: beat types, action codes and sizing constants.
`timescale 1ns / 1ps

package rcs_pkg;

  // Action codes carried by an input beat.
  localparam logic [1:0] ACT_INIT   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_SPILL  = 2'd2;

  // Coder datapath widths.
  localparam int LOW_W   = 64;
  localparam int RANGE_W = 64;
  localparam int SCALE_W = 17;
  localparam int SLOW_W  = 16;
  localparam int SRNG_W  = 17;

  // Range value after reset or init: 2^63.
  localparam logic [RANGE_W-1:0] RANGE_INIT = {1'b1, {(RANGE_W-1){1'b0}}};

  // Iterative divider: quotient bits retired per cycle and cycle count.
  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_STEPS          = RANGE_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

  // Shared multiplier: half of the quotient times a 17-bit count.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Input beat.
  typedef struct packed {
    logic [1:0]         action;
    logic [SCALE_W-1:0] scale;
    logic [SLOW_W-1:0]  sym_low;
    logic [SRNG_W-1:0]  sym_range;
  } item_t;

  // Result beat.
  typedef struct packed {
    logic       carry_out;
    logic       bytes_valid;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
  } result_t;

endpackage

### design/rcs_div.sv
// Iterative restoring divider: 64-bit dividend by 17-bit divisor, four quotient bits per cycle.
`timescale 1ns / 1ps

module rcs_div import rcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RANGE_W-1:0]   dividend,
  input  logic [SCALE_W-1:0]   divisor,
  output logic                 done,
  output logic [RANGE_W-1:0]   quotient
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RANGE_W-1:0]   quo;
  logic [RANGE_W-1:0]   quo_next;
  logic [SCALE_W-1:0]   rem;
  logic [SCALE_W-1:0]   rem_next;
  logic [SCALE_W-1:0]   dvs;

  // Four restoring steps: dividend bits shift out the top of quo while
  // quotient bits shift in at the bottom.
  always_comb begin
    logic [SCALE_W:0] trial;
    logic [SCALE_W:0] diff;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      trial    = {rem_next, quo_next[RANGE_W-1]};
      quo_next = {quo_next[RANGE_W-2:0], 1'b0};
      diff     = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
        rem_next    = diff[SCALE_W-1:0];
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[SCALE_W-1:0];
      end
    end
  end

  // Control: a start loads the operands, then DIV_STEPS iterations run.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

### design/range_coder_step_unit.sv
// Top level of the range coder step unit: sequencer, shared multiplier and coder state.
//
//   channel  | signals                          | direction | payload
//   ---------+----------------------------------+-----------+---------
//   item     | item_valid, item_ready, item     | in        | item_t
//   res      | res_valid, res_ready, res        | out       | result_t
//
// An encode beat starts the divider on acceptance, waits in it (four quotient
// bits a cycle), makes four passes through the shared 32x17 multiplier,
// finishes and loads its result in the output state. Init, spill and unknown
// actions go straight to the output state and load their result there. One
// beat is worked on at a time; item_ready is high only while the sequencer is
// idle, so no new beat is taken until the last one has loaded its result. A
// stalled result holds the sequencer in its output state. Reset is synchronous
// and sets low to 0 and the range to 2^63.
`timescale 1ns / 1ps

module range_coder_step_unit import rcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_MUL0 = 8'b0000_0100,
    S_MUL1 = 8'b0000_1000,
    S_MUL2 = 8'b0001_0000,
    S_MUL3 = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [LOW_W-1:0]   low_reg;
  logic [RANGE_W-1:0] range_reg;
  logic [SLOW_W-1:0]  slo;
  logic [SRNG_W-1:0]  sra;
  logic [LOW_W-1:0]   lo_acc;
  logic [RANGE_W-1:0] rng_acc;
  logic [MUL_P_W-1:0] prod;
  result_t            pend;

  logic               accept;
  logic               div_start;
  logic               div_done;
  logic [RANGE_W-1:0] quo;
  logic [SCALE_W-1:0] scale_sat;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic [RANGE_W-1:0] rng_sum;
  logic               renorm;
  logic               out_free;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !res_valid || res_ready;

  // A zero scale divides by one.
  assign scale_sat = (item.scale == '0) ? SCALE_W'(1) : item.scale;
  assign div_start = accept && (item.action == ACT_ENCODE);

  rcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (range_reg),
    .divisor  (scale_sat),
    .done     (div_done),
    .quotient (quo)
  );

  // Shared multiplier: low or high half of the quotient by sym_low or sym_range.
  always_comb begin
    mul_a = quo[MUL_A_W-1:0];
    mul_b = {1'b0, slo};
    unique case (state)
      S_MUL1: begin
        mul_a = quo[RANGE_W-1:MUL_A_W];
        mul_b = {1'b0, slo};
      end
      S_MUL2: begin
        mul_a = quo[MUL_A_W-1:0];
        mul_b = sra;
      end
      S_MUL3: begin
        mul_a = quo[RANGE_W-1:MUL_A_W];
        mul_b = sra;
      end
      default: begin
        mul_a = quo[MUL_A_W-1:0];
        mul_b = {1'b0, slo};
      end
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // New range: low partial product plus the high one shifted by 32, modulo 2^64.
  assign rng_sum = rng_acc + {prod[MUL_A_W-1:0], {MUL_A_W{1'b0}}};
  // Renormalize when the range is at most 2^32.
  assign renorm  = (rng_sum[RANGE_W-1:33] == '0) &&
                   (!rng_sum[32] || (rng_sum[31:0] == '0));

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (item.action == ACT_ENCODE) ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Coder state: init and the end of an encode update low and range; spill clears bit 63 of low.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_reg   <= '0;
      range_reg <= RANGE_INIT;
    end else if (accept && (item.action == ACT_INIT)) begin
      low_reg   <= '0;
      range_reg <= RANGE_INIT;
    end else if (accept && (item.action == ACT_SPILL)) begin
      low_reg[LOW_W-1] <= 1'b0;
    end else if (state == S_FIN) begin
      if (renorm) begin
        low_reg   <= {1'b0, lo_acc[38:0], 24'b0};
        range_reg <= {rng_sum[39:0], 24'b0};
      end else begin
        low_reg   <= lo_acc;
        range_reg <= rng_sum;
      end
    end
  end

  // Working registers of an encode beat and the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      slo  <= item.sym_low;
      sra  <= item.sym_range;
      // Only a spill reports something here: the carry held in bit 63 of low.
      pend <= {(item.action == ACT_SPILL) && low_reg[LOW_W-1], 25'b0};
    end
    unique case (state)
      S_MUL0: prod <= mul_p;
      S_MUL1: begin
        lo_acc <= low_reg + LOW_W'(prod);
        prod   <= mul_p;
      end
      S_MUL2: begin
        lo_acc <= lo_acc + {prod[MUL_A_W-1:0], {MUL_A_W{1'b0}}};
        prod   <= mul_p;
      end
      S_MUL3: begin
        rng_acc <= RANGE_W'(prod);
        prod    <= mul_p;
      end
      S_FIN: begin
        // Carry, valid flag and low bits 62..39 as three bytes.
        if (renorm) begin
          pend <= {lo_acc[63], 1'b1, lo_acc[62:39]};
        end else begin
          pend <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: a result beat waits here until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      res <= pend;
    end
  end

endmodule
